// ===== sv/spcc_pkg.sv =====
// Shared types and constants for the servo pulse command controller.
package spcc_pkg;

    // Item kinds carried on the input tuser field.
    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_TICK  = 2'd0;
    localparam opcode_t OP_BYTE  = 2'd1;
    localparam opcode_t OP_CLEAR = 2'd2;

    // Configuration register indexes.
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_SLEW_STEP    = 2'd0;
    localparam cfg_index_t CFG_GAP_INTERVAL = 2'd1;
    localparam cfg_index_t CFG_TIMEOUT      = 2'd2;

    localparam logic [7:0]  SLEW_STEP_RESET = 8'd5;
    localparam logic [15:0] GAP_RESET       = 16'd18000;
    localparam logic [7:0]  TIMEOUT_RESET   = 8'd10;

    localparam logic [11:0] SERVO_HOME   = 12'd1750;
    localparam logic [11:0] TARGET_BASE  = 12'd1065;
    localparam logic [10:0] TARGET_SCALE = 11'd7;
    localparam logic [7:0]  IDLE_MAX     = 8'd255;

    // Command characters.
    localparam logic [7:0] CMD_SERVO   = 8'h73; // s
    localparam logic [7:0] CMD_RECON   = 8'h61; // a
    localparam logic [7:0] CMD_IMG_Z   = 8'h7A; // z
    localparam logic [7:0] CMD_IMG_H   = 8'h68; // h
    localparam logic [7:0] CMD_IMG_X   = 8'h78; // x
    localparam logic [7:0] CMD_IMG_G   = 8'h67; // g
    localparam logic [7:0] CMD_IMG_F   = 8'h66; // f
    localparam logic [7:0] CMD_IMG_P   = 8'h70; // p
    localparam logic [7:0] CMD_MODE    = 8'h69; // i
    localparam logic [7:0] CMD_RECORD  = 8'h64; // d
    localparam logic [7:0] CMD_AVOID   = 8'h77; // w

    // Arguments of the mode command.
    localparam logic [7:0] ARG_MODE_ON     = 8'd10;
    localparam logic [7:0] ARG_MODE_OFF    = 8'd11;
    localparam logic [7:0] ARG_PREVIEW_ON  = 8'd12;
    localparam logic [7:0] ARG_PREVIEW_OFF = 8'd13;

    // Arguments that qualify the request and avoidance commands.
    localparam logic [7:0] ARG_IMAGE     = 8'd0;
    localparam logic [7:0] ARG_RECORD    = 8'd1;
    localparam logic [7:0] ARG_AVOID_OFF = 8'd0;
    localparam logic [7:0] ARG_AVOID_ON  = 8'd1;

    // Pending request codes.
    typedef logic [3:0] request_t;
    localparam request_t REQ_NONE        = 4'd0;
    localparam request_t REQ_IMG_Z       = 4'd1;
    localparam request_t REQ_IMG_H       = 4'd2;
    localparam request_t REQ_IMG_X       = 4'd3;
    localparam request_t REQ_IMG_G       = 4'd4;
    localparam request_t REQ_IMG_F       = 4'd5;
    localparam request_t REQ_IMG_P       = 4'd6;
    localparam request_t REQ_AVOID       = 4'd7;
    localparam request_t REQ_RECORD      = 4'd8;
    localparam request_t REQ_RECONSTRUCT = 4'd13;

    typedef struct packed {
        logic [7:0]  slew_step;
        logic [15:0] gap_interval;
        logic [7:0]  timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic        servo_pin;
        logic [15:0] interval_us;
    } servo_res_t;

    typedef struct packed {
        logic        pair_done;
        logic [7:0]  command_byte;
        logic [7:0]  argument_byte;
        request_t    frame_request;
        logic        auto_mode;
        logic        auto_preview;
        logic        avoid_enable;
    } cmd_res_t;

endpackage

// ===== sv/spcc_servo.sv =====
// Servo slew, pulse/gap phase sequencing and frame timeout counting.
module spcc_servo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  spcc_pkg::opcode_t    opcode,
    input  spcc_pkg::cfg_t       cfg,
    input  logic [11:0]          target,
    output spcc_pkg::servo_res_t res,
    output logic                 restart
);

    logic [11:0] pos_reg, pos_next;
    logic        phase_reg, phase_next;
    logic [7:0]  idle_reg, idle_next;
    logic [11:0] pos_up, pos_step;
    logic [7:0]  idle_inc;
    logic [15:0] interval;

    always_comb begin
        // Rising test first, then the falling test on the updated value.
        pos_up   = (target > pos_reg) ? pos_reg + {4'b0000, cfg.slew_step} : pos_reg;
        pos_step = (target < pos_up) ? pos_up - {4'b0000, cfg.slew_step} : pos_up;
        idle_inc = (idle_reg != spcc_pkg::IDLE_MAX) ? idle_reg + 8'd1 : idle_reg;

        pos_next   = pos_reg;
        phase_next = phase_reg;
        idle_next  = idle_reg;
        interval   = '0;
        restart    = 1'b0;
        if (en) begin
            unique case (opcode)
                spcc_pkg::OP_TICK: begin
                    pos_next = pos_step;
                    if (!phase_reg) begin
                        interval   = {4'b0000, pos_step};
                        phase_next = 1'b1;
                    end else begin
                        interval   = cfg.gap_interval;
                        phase_next = 1'b0;
                        if (idle_inc >= cfg.timeout_ticks) begin
                            idle_next = cfg.timeout_ticks;
                            restart   = 1'b1;
                        end else begin
                            idle_next = idle_inc;
                        end
                    end
                end
                spcc_pkg::OP_BYTE: begin
                    idle_next = '0;
                end
                default: begin
                end
            endcase
        end
        res.servo_pin   = phase_next;
        res.interval_us = interval;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= spcc_pkg::SERVO_HOME;
            phase_reg <= 1'b0;
            idle_reg  <= '0;
        end else begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            idle_reg  <= idle_next;
        end
    end

endmodule

// ===== sv/spcc_cmd.sv =====
// Two-byte command assembly and decoding of target, requests and flags.
module spcc_cmd (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  spcc_pkg::opcode_t  opcode,
    input  logic [7:0]         rx_byte,
    input  logic               restart,
    output logic [11:0]        target,
    output spcc_pkg::cmd_res_t res
);

    logic               index_reg, index_next;
    logic [7:0]         held_reg;
    logic               held_we;
    logic [11:0]        target_reg, target_next;
    spcc_pkg::request_t req_reg, req_next;
    logic               mode_reg, mode_next;
    logic               preview_reg, preview_next;
    logic               avoid_reg, avoid_next;
    logic [10:0]        scaled;
    logic               done;
    logic               arg_zero;

    always_comb begin
        scaled   = 11'({3'b000, ~rx_byte} * spcc_pkg::TARGET_SCALE);
        arg_zero = (rx_byte == spcc_pkg::ARG_IMAGE);

        index_next   = index_reg;
        held_we      = 1'b0;
        target_next  = target_reg;
        req_next     = req_reg;
        mode_next    = mode_reg;
        preview_next = preview_reg;
        avoid_next   = avoid_reg;
        done         = 1'b0;

        if (en) begin
            unique case (opcode)
                spcc_pkg::OP_TICK: begin
                    if (restart) begin
                        index_next = 1'b0;
                    end
                end
                spcc_pkg::OP_BYTE: begin
                    if (!index_reg) begin
                        held_we    = 1'b1;
                        index_next = 1'b1;
                    end else begin
                        index_next = 1'b0;
                        done       = 1'b1;
                        unique case (held_reg)
                            spcc_pkg::CMD_SERVO:
                                target_next = spcc_pkg::TARGET_BASE + {1'b0, scaled};
                            spcc_pkg::CMD_RECON: req_next = spcc_pkg::REQ_RECONSTRUCT;
                            spcc_pkg::CMD_IMG_Z: if (arg_zero) req_next = spcc_pkg::REQ_IMG_Z;
                            spcc_pkg::CMD_IMG_H: if (arg_zero) req_next = spcc_pkg::REQ_IMG_H;
                            spcc_pkg::CMD_IMG_X: if (arg_zero) req_next = spcc_pkg::REQ_IMG_X;
                            spcc_pkg::CMD_IMG_G: if (arg_zero) req_next = spcc_pkg::REQ_IMG_G;
                            spcc_pkg::CMD_IMG_F: if (arg_zero) req_next = spcc_pkg::REQ_IMG_F;
                            spcc_pkg::CMD_IMG_P: if (arg_zero) req_next = spcc_pkg::REQ_IMG_P;
                            spcc_pkg::CMD_MODE: begin
                                if (rx_byte == spcc_pkg::ARG_MODE_ON)     mode_next    = 1'b1;
                                if (rx_byte == spcc_pkg::ARG_MODE_OFF)    mode_next    = 1'b0;
                                if (rx_byte == spcc_pkg::ARG_PREVIEW_ON)  preview_next = 1'b1;
                                if (rx_byte == spcc_pkg::ARG_PREVIEW_OFF) preview_next = 1'b0;
                            end
                            spcc_pkg::CMD_RECORD:
                                if (rx_byte == spcc_pkg::ARG_RECORD) begin
                                    req_next = spcc_pkg::REQ_RECORD;
                                end
                            spcc_pkg::CMD_AVOID: begin
                                if (rx_byte == spcc_pkg::ARG_AVOID_OFF) avoid_next = 1'b0;
                                if (rx_byte == spcc_pkg::ARG_AVOID_ON) begin
                                    avoid_next = 1'b1;
                                    req_next   = spcc_pkg::REQ_AVOID;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                spcc_pkg::OP_CLEAR: begin
                    req_next = spcc_pkg::REQ_NONE;
                end
                default: begin
                end
            endcase
        end

        res.pair_done     = done;
        res.command_byte  = done ? held_reg : 8'd0;
        res.argument_byte = done ? rx_byte : 8'd0;
        res.frame_request = req_next;
        res.auto_mode     = mode_next;
        res.auto_preview  = preview_next;
        res.avoid_enable  = avoid_next;
    end

    assign target = target_reg;

    // The held command is payload only; it is read after a first byte wrote it.
    always_ff @(posedge aclk) begin
        if (held_we) begin
            held_reg <= rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg   <= 1'b0;
            target_reg  <= spcc_pkg::SERVO_HOME;
            req_reg     <= spcc_pkg::REQ_NONE;
            mode_reg    <= 1'b0;
            preview_reg <= 1'b0;
            avoid_reg   <= 1'b0;
        end else begin
            index_reg   <= index_next;
            target_reg  <= target_next;
            req_reg     <= req_next;
            mode_reg    <= mode_next;
            preview_reg <= preview_next;
            avoid_reg   <= avoid_next;
        end
    end

endmodule

// ===== sv/servo_pulse_command_controller_top.sv =====
// Top level of the servo pulse sequencer with serial command decoding.
//
// Input beats carry one item each: s_tuser gives the kind (timer tick, received
// serial byte, or acknowledge of the pending frame request) and s_tdata gives
// the received byte, which only matters for the byte kind. Every input beat
// produces exactly one result beat on the m_ channel, in order.
// A result reports the servo pin level and the timer interval to program, an
// echo of a completed command/argument pair, and the current request code and
// mode flags, all as they stand after the item.
// An accepted beat is held in the input register and is then loaded into the
// result register, which drives m_tvalid; a stall on m_tready can keep it in
// the input register. Throughput is one beat per cycle while m_tready stays
// high, limited only by the single-pass update between those two registers.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more beat; s_tready then drops until m_tready returns.
// Reset (aresetn low, synchronous) empties both registers and returns the
// servo to its home position with no pending request and all flags clear.
// The configuration port writes slew step, gap interval and timeout count; it
// is meant to be written only while no beat is in flight.
module servo_pulse_command_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [0] servo_pin, [16:1] interval_us, [17] pair_done,
                                   // [25:18] command_byte, [33:26] argument_byte,
                                   // [37:34] frame_request, [38] auto_mode,
                                   // [39] auto_preview, [40] avoid_enable, [47:41] zero
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    spcc_pkg::cfg_t       cfg_reg;
    logic                 in_valid_reg;
    spcc_pkg::opcode_t    in_op_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    logic [47:0]          out_data_reg;
    logic                 advance;
    logic                 restart;
    logic [11:0]          target;
    spcc_pkg::servo_res_t servo_res;
    spcc_pkg::cmd_res_t   cmd_res;
    logic [47:0]          out_data_next;

    // The item in the input register is processed whenever the result
    // register is empty or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slew_step     <= spcc_pkg::SLEW_STEP_RESET;
            cfg_reg.gap_interval  <= spcc_pkg::GAP_RESET;
            cfg_reg.timeout_ticks <= spcc_pkg::TIMEOUT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                spcc_pkg::CFG_SLEW_STEP:    cfg_reg.slew_step     <= cfg_wdata[7:0];
                spcc_pkg::CFG_GAP_INTERVAL: cfg_reg.gap_interval  <= cfg_wdata;
                spcc_pkg::CFG_TIMEOUT:      cfg_reg.timeout_ticks <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    spcc_servo u_servo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .opcode  (in_op_reg),
        .cfg     (cfg_reg),
        .target  (target),
        .res     (servo_res),
        .restart (restart)
    );

    spcc_cmd u_cmd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .opcode  (in_op_reg),
        .rx_byte (in_byte_reg),
        .restart (restart),
        .target  (target),
        .res     (cmd_res)
    );

    assign out_data_next = {7'b0000000,
                            cmd_res.avoid_enable,
                            cmd_res.auto_preview,
                            cmd_res.auto_mode,
                            cmd_res.frame_request,
                            cmd_res.argument_byte,
                            cmd_res.command_byte,
                            cmd_res.pair_done,
                            servo_res.interval_us,
                            servo_res.servo_pin};

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // A result without a completed pair carries no echo.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[17] |-> m_tdata[33:18] == 16'd0)
        else $error("echo fields set without a completed pair");

    // A pulse interval is a 12-bit servo position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[16:13] == 4'd0)
        else $error("pulse interval exceeds position range");

    // Only defined request codes ever appear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[37:34] <= spcc_pkg::REQ_RECORD ||
                      m_tdata[37:34] == spcc_pkg::REQ_RECONSTRUCT))
        else $error("undefined frame request code");

    // With an empty result register the block must take a new beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while result register is empty");

    // A processed item always leaves a result beat behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed item produced no result beat");

endmodule

// ===== verif/servo_pulse_command_controller_top_tb.sv =====
// Self-checking testbench for the servo pulse command controller top level.
module servo_pulse_command_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The fourth input kind has no meaning in the block and must leave it untouched.
    localparam spcc_pkg::opcode_t OP_UNUSED = 2'd3;

    // Result beat as it sits on m_tdata, declared from the top bit down.
    typedef struct packed {
        logic [6:0]         pad;
        logic               avoid_enable;
        logic               auto_preview;
        logic               auto_mode;
        spcc_pkg::request_t frame_request;
        logic [7:0]         argument_byte;
        logic [7:0]         command_byte;
        logic               pair_done;
        logic [15:0]        interval_us;
        logic               servo_pin;
    } servo_beat_t;

    // One line of the directed sequence; the beat is only used when checked is set.
    typedef struct packed {
        spcc_pkg::opcode_t op;
        logic [7:0]        data;
        logic              checked;
        servo_beat_t       beat;
    } directed_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic [1:0]  s_tuser   = spcc_pkg::OP_TICK;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = spcc_pkg::CFG_SLEW_STEP;
    logic [15:0] cfg_wdata = 16'h0000;

    // Register copies kept in step with every configuration write.
    logic [7:0]  slew_cfg    = spcc_pkg::SLEW_STEP_RESET;
    logic [15:0] gap_cfg     = spcc_pkg::GAP_RESET;
    logic [7:0]  timeout_cfg = spcc_pkg::TIMEOUT_RESET;

    // Controller state as the block should hold it.
    logic [11:0]        position     = spcc_pkg::SERVO_HOME;
    logic [11:0]        target       = spcc_pkg::SERVO_HOME;
    logic               in_pulse     = 1'b0;
    logic [7:0]         idle_gaps    = 8'd0;
    logic               have_command = 1'b0;
    logic [7:0]         held_cmd     = 8'h00;
    spcc_pkg::request_t request      = spcc_pkg::REQ_NONE;
    logic               mode_on      = 1'b0;
    logic               preview_on   = 1'b0;
    logic               avoid_on     = 1'b0;

    servo_beat_t beats_in_flight[$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          idle_pct       = 0;
    int          stall_pct      = 0;
    int          holds_asked    = 0;
    int          holds_done     = 0;
    int          hold_left      = 0;

    logic [7:0]  command_set [0:10] = '{spcc_pkg::CMD_SERVO, spcc_pkg::CMD_RECON,
                                        spcc_pkg::CMD_IMG_Z, spcc_pkg::CMD_IMG_H,
                                        spcc_pkg::CMD_IMG_X, spcc_pkg::CMD_IMG_G,
                                        spcc_pkg::CMD_IMG_F, spcc_pkg::CMD_IMG_P,
                                        spcc_pkg::CMD_MODE, spcc_pkg::CMD_RECORD,
                                        spcc_pkg::CMD_AVOID};

    servo_pulse_command_controller_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Applies one item to the controller state and returns the beat it must produce.
    function automatic servo_beat_t advance_controller(spcc_pkg::opcode_t op, logic [7:0] rx);
        servo_beat_t beat;
        beat = '0;
        case (op)
            spcc_pkg::OP_TICK: begin
                // The upward test runs first; the downward test sees the moved position.
                if (target > position) position = position + slew_cfg;
                if (target < position) position = position - slew_cfg;
                if (!in_pulse) begin
                    beat.interval_us = {4'h0, position};
                    in_pulse = 1'b1;
                end else begin
                    beat.interval_us = gap_cfg;
                    in_pulse = 1'b0;
                    if (idle_gaps < spcc_pkg::IDLE_MAX) idle_gaps++;
                    if (idle_gaps >= timeout_cfg) begin
                        idle_gaps = timeout_cfg;
                        have_command = 1'b0;
                    end
                end
            end
            spcc_pkg::OP_BYTE: begin
                idle_gaps = 8'd0;
                if (!have_command) begin
                    held_cmd = rx;
                    have_command = 1'b1;
                end else begin
                    have_command = 1'b0;
                    beat.pair_done = 1'b1;
                    beat.command_byte = held_cmd;
                    beat.argument_byte = rx;
                    case (held_cmd)
                        spcc_pkg::CMD_SERVO:
                            target = 12'(int'(spcc_pkg::TARGET_BASE)
                                         + int'(8'hFF - rx) * int'(spcc_pkg::TARGET_SCALE));
                        spcc_pkg::CMD_RECON: request = spcc_pkg::REQ_RECONSTRUCT;
                        spcc_pkg::CMD_IMG_Z:
                            if (rx == spcc_pkg::ARG_IMAGE) request = spcc_pkg::REQ_IMG_Z;
                        spcc_pkg::CMD_IMG_H:
                            if (rx == spcc_pkg::ARG_IMAGE) request = spcc_pkg::REQ_IMG_H;
                        spcc_pkg::CMD_IMG_X:
                            if (rx == spcc_pkg::ARG_IMAGE) request = spcc_pkg::REQ_IMG_X;
                        spcc_pkg::CMD_IMG_G:
                            if (rx == spcc_pkg::ARG_IMAGE) request = spcc_pkg::REQ_IMG_G;
                        spcc_pkg::CMD_IMG_F:
                            if (rx == spcc_pkg::ARG_IMAGE) request = spcc_pkg::REQ_IMG_F;
                        spcc_pkg::CMD_IMG_P:
                            if (rx == spcc_pkg::ARG_IMAGE) request = spcc_pkg::REQ_IMG_P;
                        spcc_pkg::CMD_MODE: begin
                            if (rx == spcc_pkg::ARG_MODE_ON) mode_on = 1'b1;
                            if (rx == spcc_pkg::ARG_MODE_OFF) mode_on = 1'b0;
                            if (rx == spcc_pkg::ARG_PREVIEW_ON) preview_on = 1'b1;
                            if (rx == spcc_pkg::ARG_PREVIEW_OFF) preview_on = 1'b0;
                        end
                        spcc_pkg::CMD_RECORD:
                            if (rx == spcc_pkg::ARG_RECORD) request = spcc_pkg::REQ_RECORD;
                        spcc_pkg::CMD_AVOID: begin
                            if (rx == spcc_pkg::ARG_AVOID_OFF) avoid_on = 1'b0;
                            if (rx == spcc_pkg::ARG_AVOID_ON) begin
                                avoid_on = 1'b1;
                                request = spcc_pkg::REQ_AVOID;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            spcc_pkg::OP_CLEAR: request = spcc_pkg::REQ_NONE;
            default: ;
        endcase
        beat.servo_pin = in_pulse;
        beat.frame_request = request;
        beat.auto_mode = mode_on;
        beat.auto_preview = preview_on;
        beat.avoid_enable = avoid_on;
        return beat;
    endfunction

    function automatic directed_row_t row(spcc_pkg::opcode_t op, logic [7:0] data,
                                          logic checked, logic pin, logic [15:0] interval,
                                          logic done, logic [7:0] cmd, logic [7:0] arg,
                                          spcc_pkg::request_t req);
        directed_row_t r;
        r = '0;
        r.op = op;
        r.data = data;
        r.checked = checked;
        r.beat.servo_pin = pin;
        r.beat.interval_us = interval;
        r.beat.pair_done = done;
        r.beat.command_byte = cmd;
        r.beat.argument_byte = arg;
        r.beat.frame_request = req;
        return r;
    endfunction

    // Offers one beat, waits for the handshake, records what must come back, then
    // leaves the input idle for a random stretch when the phase asks for it.
    task automatic send_item(spcc_pkg::opcode_t op, logic [7:0] data, logic checked,
                             servo_beat_t fixed_beat);
        servo_beat_t beat;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        beat = advance_controller(op, data);
        if (checked) beat = fixed_beat;
        beats_in_flight.push_back(beat);
        items_sent++;
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Command pairs with random content are the largest share; the rest are ticks,
    // stray bytes that shift the pairing, acknowledges and unused kinds.
    task automatic send_random_unit();
        int         pick;
        int         stretch;
        logic [7:0] cmd;
        logic [7:0] arg;
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_item(spcc_pkg::OP_TICK, 8'($urandom), 1'b0, '0);
        end else if (pick < 75) begin
            cmd = ($urandom_range(11) == 0) ? 8'($urandom) : command_set[$urandom_range(10)];
            arg = 8'($urandom);
            if ($urandom_range(1) == 0) begin
                case (cmd)
                    spcc_pkg::CMD_IMG_Z, spcc_pkg::CMD_IMG_H, spcc_pkg::CMD_IMG_X,
                    spcc_pkg::CMD_IMG_G, spcc_pkg::CMD_IMG_F, spcc_pkg::CMD_IMG_P:
                        arg = spcc_pkg::ARG_IMAGE;
                    spcc_pkg::CMD_MODE:
                        arg = 8'($urandom_range(spcc_pkg::ARG_MODE_ON,
                                                spcc_pkg::ARG_PREVIEW_OFF));
                    spcc_pkg::CMD_RECORD: arg = spcc_pkg::ARG_RECORD;
                    spcc_pkg::CMD_AVOID:
                        arg = ($urandom_range(1) == 0) ? spcc_pkg::ARG_AVOID_OFF
                                                       : spcc_pkg::ARG_AVOID_ON;
                    default: ;
                endcase
            end
            send_item(spcc_pkg::OP_BYTE, cmd, 1'b0, '0);
            // Now and then ticks split the pair, sometimes long enough to time it out.
            if ($urandom_range(9) == 0) begin
                stretch = $urandom_range(2 * int'(timeout_cfg) + 2);
                if (stretch > 24) stretch = $urandom_range(24);
                repeat (stretch) send_item(spcc_pkg::OP_TICK, 8'($urandom), 1'b0, '0);
            end
            send_item(spcc_pkg::OP_BYTE, arg, 1'b0, '0);
        end else if (pick < 85) begin
            send_item(spcc_pkg::OP_BYTE, 8'($urandom), 1'b0, '0);
        end else if (pick < 94) begin
            send_item(spcc_pkg::OP_CLEAR, 8'($urandom), 1'b0, '0);
        end else begin
            send_item(OP_UNUSED, 8'($urandom), 1'b0, '0);
        end
    endtask

    // Waits until every result has come back, then lets the clock run on before returning.
    task automatic wait_drained();
        while (beats_in_flight.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all three registers on consecutive cycles while the block is idle.
    task automatic write_config(logic [7:0] slew, logic [15:0] gap, logic [7:0] timeout);
        cfg_we    <= 1'b1;
        cfg_index <= spcc_pkg::CFG_SLEW_STEP;
        cfg_wdata <= {8'h00, slew};
        @(posedge aclk);
        cfg_index <= spcc_pkg::CFG_GAP_INTERVAL;
        cfg_wdata <= gap;
        @(posedge aclk);
        cfg_index <= spcc_pkg::CFG_TIMEOUT;
        cfg_wdata <= {8'h00, timeout};
        @(posedge aclk);
        cfg_we <= 1'b0;
        slew_cfg    = slew;
        gap_cfg     = gap;
        timeout_cfg = timeout;
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // The receiver either follows the phase's stall rate or, when a hold is
    // asked for, keeps tready low until the hold counter runs out.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_asked != holds_done) begin
            m_tready   <= 1'b0;
            hold_left  <= 64;
            holds_done <= holds_done + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Every accepted result beat is compared with the oldest outstanding one.
    always @(posedge aclk) begin : result_check
        servo_beat_t seen;
        servo_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata;
            if (beats_in_flight.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = beats_in_flight.pop_front();
                check_field("servo_pin", want.servo_pin, seen.servo_pin);
                check_field("interval_us", want.interval_us, seen.interval_us);
                check_field("pair_done", want.pair_done, seen.pair_done);
                check_field("command_byte", want.command_byte, seen.command_byte);
                check_field("argument_byte", want.argument_byte, seen.argument_byte);
                check_field("frame_request", want.frame_request, seen.frame_request);
                check_field("auto_mode", want.auto_mode, seen.auto_mode);
                check_field("auto_preview", want.auto_preview, seen.auto_preview);
                check_field("avoid_enable", want.avoid_enable, seen.avoid_enable);
                check_field("padding", want.pad, seen.pad);
            end
        end
    end

    initial begin : stimulus
        directed_row_t directed_rows [0:23];
        int            phase;
        int            phase_end;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset configuration. The first rows start a pulse at the
        // home position, a gap at the reset gap interval, the unused kind, and servo
        // commands at both argument extremes; the rest walk the other commands.
        directed_rows = '{
            row(spcc_pkg::OP_TICK, 8'h00, 1'b1, 1'b1, {4'h0, spcc_pkg::SERVO_HOME}, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_TICK, 8'hFF, 1'b1, 1'b0, spcc_pkg::GAP_RESET, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(OP_UNUSED, 8'hA5, 1'b1, 1'b0, 16'd0, 1'b0, 8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, spcc_pkg::CMD_SERVO, 1'b1, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, 8'h00, 1'b1, 1'b0, 16'd0, 1'b1,
                spcc_pkg::CMD_SERVO, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, spcc_pkg::CMD_SERVO, 1'b1, 1'b1, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, 8'hFF, 1'b1, 1'b1, 16'd0, 1'b1,
                spcc_pkg::CMD_SERVO, 8'hFF, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, spcc_pkg::CMD_RECON, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, 8'h5A, 1'b1, 1'b1, 16'd0, 1'b1,
                spcc_pkg::CMD_RECON, 8'h5A, spcc_pkg::REQ_RECONSTRUCT),
            row(spcc_pkg::OP_CLEAR, 8'hFF, 1'b1, 1'b1, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, spcc_pkg::CMD_AVOID, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, spcc_pkg::ARG_AVOID_ON, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, spcc_pkg::CMD_MODE, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, spcc_pkg::ARG_MODE_ON, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, spcc_pkg::CMD_MODE, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, spcc_pkg::ARG_PREVIEW_ON, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, spcc_pkg::CMD_RECORD, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, spcc_pkg::ARG_RECORD, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, spcc_pkg::CMD_IMG_Z, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, spcc_pkg::ARG_IMAGE, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, 8'hFF, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_BYTE, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE),
            row(spcc_pkg::OP_TICK, 8'h3C, 1'b0, 1'b0, 16'd0, 1'b0,
                8'h00, 8'h00, spcc_pkg::REQ_NONE)
        };
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].checked,
                      directed_rows[i].beat);
        end
        s_tvalid <= 1'b0;
        wait_drained();

        // Random phases, each with its own register setting and handshake pattern.
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_config(8'd1, 16'd1000, 8'd1);
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    write_config(8'd255, 16'd65535, 8'd255);
                    idle_pct  = 87;
                    stall_pct = 0;
                end
                2: begin
                    write_config(8'($urandom_range(1, 255)), 16'($urandom_range(1000, 65535)),
                                 8'($urandom_range(1, 20)));
                    idle_pct  = 0;
                    stall_pct = 87;
                end
                3: begin
                    // A zero timeout restarts pairing on every gap phase.
                    write_config(8'($urandom_range(1, 255)), 16'($urandom_range(1000, 65535)),
                                 8'd0);
                    idle_pct  = 26;
                    stall_pct = 26;
                end
                default: begin
                    write_config(spcc_pkg::SLEW_STEP_RESET, spcc_pkg::GAP_RESET,
                                 spcc_pkg::TIMEOUT_RESET);
                    idle_pct  = 0;
                    stall_pct = 0;
                    // Hold the receiver off while items keep coming, so both
                    // registers fill and s_tready has to drop.
                    holds_asked++;
                end
            endcase
            phase_end = items_sent + 265;
            while (items_sent < phase_end) send_random_unit();
            s_tvalid <= 1'b0;
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("servo_pulse_command_controller_top_tb: PASS");
        end else begin
            $display("servo_pulse_command_controller_top_tb: FAIL");
        end
        $finish;
    end

    // Far beyond the slowest correct run; reaching it means the block hung.
    initial begin
        #(2_000_000);
        $display("servo_pulse_command_controller_top_tb: FAIL");
        $finish;
    end

endmodule
